[hw/rtl/kms_pkg.sv]
// Shared command and status codes and the pointer-update request type.
package kms_pkg;

  typedef logic [1:0] cmd_t;
  typedef logic [1:0] status_t;

  localparam cmd_t CMD_APPEND = 2'd0;
  localparam cmd_t CMD_POP    = 2'd1;
  localparam cmd_t CMD_CLEAR  = 2'd2;

  localparam status_t STAT_DONE  = 2'd0;
  localparam status_t STAT_DROP  = 2'd1;
  localparam status_t STAT_EMPTY = 2'd2;

  // Pointer table update request; at most one of these is set per cycle.
  typedef struct packed {
    logic append;
    logic pop;
    logic clear;
  } ptr_op_t;

endpackage

[hw/rtl/kms_store.sv]
// Element memory: one write port, one read port with registered read data.
module kms_store #(
  parameter int WORDS = 512,
  localparam int AW = $clog2(WORDS)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [WORDS];
  logic [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/kms_ptrs.sv]
// Per-list head, tail and fill count registers with append, pop and clear updates.
module kms_ptrs #(
  parameter int LIST_COUNT = 8,
  parameter int LIST_DEPTH = 64,
  localparam int LW = $clog2(LIST_COUNT),
  localparam int PW = $clog2(LIST_DEPTH),
  localparam int FW = $clog2(LIST_DEPTH + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [LW-1:0]   app_list,
  output logic [PW-1:0]   app_tail,
  output logic            app_full,
  input  logic [LW-1:0]   scan_list,
  output logic [PW-1:0]   scan_head,
  output logic            scan_nonempty,
  input  kms_pkg::ptr_op_t op,
  input  logic [LW-1:0]   upd_list
);
  import kms_pkg::*;

  logic [PW-1:0] head_r [LIST_COUNT];
  logic [PW-1:0] tail_r [LIST_COUNT];
  logic [FW-1:0] fill_r [LIST_COUNT];
  logic [PW-1:0] head_nxt [LIST_COUNT];
  logic [PW-1:0] tail_nxt [LIST_COUNT];
  logic [FW-1:0] fill_nxt [LIST_COUNT];

  function automatic logic [PW-1:0] next_pos(input logic [PW-1:0] p);
    next_pos = (p == PW'(LIST_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign app_tail      = tail_r[app_list];
  assign app_full      = (fill_r[app_list] == FW'(LIST_DEPTH));
  assign scan_head     = head_r[scan_list];
  assign scan_nonempty = (fill_r[scan_list] != '0);

  always_comb begin
    for (int i = 0; i < LIST_COUNT; i++) begin
      head_nxt[i] = head_r[i];
      tail_nxt[i] = tail_r[i];
      fill_nxt[i] = fill_r[i];
      if (op.clear) begin
        head_nxt[i] = '0;
        tail_nxt[i] = '0;
        fill_nxt[i] = '0;
      end else if (upd_list == LW'(i)) begin
        if (op.append) begin
          tail_nxt[i] = next_pos(tail_r[i]);
          fill_nxt[i] = fill_r[i] + 1'b1;
        end else if (op.pop) begin
          head_nxt[i] = next_pos(head_r[i]);
          fill_nxt[i] = fill_r[i] - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < LIST_COUNT; i++) begin
      if (!rst_n) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        fill_r[i] <= '0;
      end else begin
        head_r[i] <= head_nxt[i];
        tail_r[i] <= tail_nxt[i];
        fill_r[i] <= fill_nxt[i];
      end
    end
  end

`ifndef SYNTHESIS
  // The control never appends to a full list or pops an empty one.
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    (op.append && !op.clear) |-> (fill_r[upd_list] != FW'(LIST_DEPTH)))
    else $error("append to a full list");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    (op.pop && !op.clear) |-> (fill_r[upd_list] != '0))
    else $error("pop from an empty list");
  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({op.append, op.pop, op.clear}) <= 1)
    else $error("more than one pointer update at once");
`endif

endmodule

[hw/rtl/k_way_sorted_merge.sv]
// Top level: command decode, pop scan over list heads in memory, result register.
// Append, clear and unused commands: result strobe in the cycle after accept, busy stays low,
//   so a new request can be taken every cycle.
// Pop: busy while ST_SCAN reads each list head from the element memory in turn
//   (one read per cycle, registered read data) and ST_DRAIN registers the result strobe.
// Reset (synchronous, rst_n low) empties all lists; element memory contents are not cleared.
// Results are presented for one cycle only; the receiver cannot stall.
module k_way_sorted_merge #(
  parameter int LIST_COUNT = 8,
  parameter int LIST_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  kms_pkg::cmd_t         in_cmd,
  input  logic [2:0]            in_list_index,
  input  logic signed [31:0]    in_value,
  output logic                  out_valid,
  output logic signed [31:0]    out_merged_value,
  output logic [2:0]            out_source_list,
  output kms_pkg::status_t      out_status
);
  import kms_pkg::*;

  localparam int LW    = $clog2(LIST_COUNT);
  localparam int PW    = $clog2(LIST_DEPTH);
  localparam int WORDS = LIST_COUNT * LIST_DEPTH;
  localparam int AW    = $clog2(WORDS);
  // Wide enough for the index port and for LIST_COUNT itself in the range check.
  localparam int IXW   = ($clog2(LIST_COUNT + 1) > 3) ? $clog2(LIST_COUNT + 1) : 3;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic [LW-1:0] sc_r, sc_nxt;
  logic [LW-1:0] cmp_list_r, cmp_list_nxt;
  logic        cmp_vld_r, cmp_vld_nxt;
  logic        found_r, found_nxt;
  logic [LW-1:0] best_r, best_nxt;
  logic signed [31:0] best_val_r, best_val_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic signed [31:0] out_val_r, out_val_nxt;
  logic [2:0]  out_src_r, out_src_nxt;
  status_t     out_status_r, out_status_nxt;

  logic          accept;
  logic [IXW-1:0] idx_w;
  logic          in_range;
  logic [LW-1:0] app_list;
  logic [PW-1:0] app_tail;
  logic          app_full;
  logic [PW-1:0] scan_head;
  logic          scan_nonempty;
  ptr_op_t       op;
  logic [LW-1:0] upd_list;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   rdata;
  logic          take;

  assign accept   = start && (state_r == ST_IDLE);
  assign busy     = (state_r != ST_IDLE);
  assign idx_w    = IXW'(in_list_index);
  assign in_range = (idx_w < IXW'(LIST_COUNT));
  assign app_list = idx_w[LW-1:0];

  assign waddr = AW'(app_list) * AW'(LIST_DEPTH) + AW'(app_tail);
  assign raddr = AW'(sc_r) * AW'(LIST_DEPTH) + AW'(scan_head);

  kms_store #(.WORDS(WORDS)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (in_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  kms_ptrs #(.LIST_COUNT(LIST_COUNT), .LIST_DEPTH(LIST_DEPTH)) u_ptrs (
    .clk           (clk),
    .rst_n         (rst_n),
    .app_list      (app_list),
    .app_tail      (app_tail),
    .app_full      (app_full),
    .scan_list     (sc_r),
    .scan_head     (scan_head),
    .scan_nonempty (scan_nonempty),
    .op            (op),
    .upd_list      (upd_list)
  );

  // Ties go to the later (higher-numbered) list, hence <=.
  assign take = cmp_vld_r && (!found_r || ($signed(rdata) <= best_val_r));

  always_comb begin
    found_nxt    = found_r;
    best_nxt     = best_r;
    best_val_nxt = best_val_r;
    if (take) begin
      found_nxt    = 1'b1;
      best_nxt     = cmp_list_r;
      best_val_nxt = $signed(rdata);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    sc_nxt         = sc_r;
    cmp_list_nxt   = sc_r;
    cmp_vld_nxt    = 1'b0;
    out_valid_nxt  = 1'b0;
    out_val_nxt    = '0;
    out_src_nxt    = '0;
    out_status_nxt = STAT_DONE;
    op             = '0;
    upd_list       = app_list;
    we             = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          case (in_cmd)
            CMD_APPEND: begin
              if (in_range && !app_full) begin
                we        = 1'b1;
                op.append = 1'b1;
              end else begin
                out_status_nxt = STAT_DROP;
              end
            end
            CMD_POP: begin
              out_valid_nxt = 1'b0;
              sc_nxt        = '0;
              state_nxt     = ST_SCAN;
            end
            CMD_CLEAR: op.clear = 1'b1;
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        // Read of list sc_r issues now; its compare happens next cycle.
        cmp_vld_nxt = scan_nonempty;
        if (sc_r == LW'(LIST_COUNT - 1)) begin
          state_nxt = ST_DRAIN;
        end else begin
          sc_nxt = sc_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        out_valid_nxt = 1'b1;
        upd_list      = best_nxt;
        if (found_nxt) begin
          op.pop      = 1'b1;
          out_val_nxt = best_val_nxt;
          out_src_nxt = 3'(best_nxt);
        end else begin
          out_status_nxt = STAT_EMPTY;
        end
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cmp_vld_r   <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      found_r     <= (state_r == ST_IDLE) ? 1'b0 : found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sc_r         <= sc_nxt;
    cmp_list_r   <= cmp_list_nxt;
    best_r       <= best_nxt;
    best_val_r   <= best_val_nxt;
    out_val_r    <= out_val_nxt;
    out_src_r    <= out_src_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_merged_value = out_val_r;
  assign out_source_list  = out_src_r;
  assign out_status       = out_status_r;

`ifndef SYNTHESIS
  a_res_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd != CMD_POP) |=> out_valid)
    else $error("non-pop request gave no result");
  a_res_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |=> (out_valid && !busy))
    else $error("pop scan ended without result");
  a_no_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while a pop is still scanning");
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STAT_DONE) |-> (out_merged_value == '0 && out_source_list == '0))
    else $error("failed request carries a value");
`endif

endmodule

[test/tb_k_way_sorted_merge.sv]
// Self-checking testbench for the k-way sorted merge block: directed table, then random requests.
module tb_k_way_sorted_merge;
  import kms_pkg::*;

  localparam int LIST_COUNT = 8;
  localparam int LIST_DEPTH = 64;
  localparam int RAND_ITEMS = 1200;
  localparam int QUIET_TAIL = 150;
  localparam int DRAIN_CYCLES = 2 * LIST_COUNT + 4;

  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         src;
    status_t            status;
  } merge_res_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [2:0]  idx;
    logic [31:0] value;
    logic        typed;
    merge_res_t  want;
  } dir_row_t;

  localparam merge_res_t RES_DONE  = {32'd0, 3'd0, STAT_DONE};
  localparam merge_res_t RES_DROP  = {32'd0, 3'd0, STAT_DROP};
  localparam merge_res_t RES_EMPTY = {32'd0, 3'd0, STAT_EMPTY};
  localparam cmd_t       CMD_UNUSED = 2'd3;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  cmd_t               in_cmd = CMD_APPEND;
  logic [2:0]         in_list_index = 3'd0;
  logic signed [31:0] in_value = 32'sd0;
  logic               busy;
  logic               out_valid;
  logic signed [31:0] out_merged_value;
  logic [2:0]         out_source_list;
  status_t            out_status;

  // Shadow copy of the list FIFOs.
  logic signed [31:0] list_mem [LIST_COUNT][LIST_DEPTH];
  int                 rd_pos [LIST_COUNT];
  int                 wr_pos [LIST_COUNT];
  int                 occupancy [LIST_COUNT];

  merge_res_t pending_results [$];
  dir_row_t   dir_rows [$];
  int         err_count = 0;
  int         sent_count = 0;
  bit         quiet = 1'b0;

  k_way_sorted_merge #(
    .LIST_COUNT(LIST_COUNT),
    .LIST_DEPTH(LIST_DEPTH)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_list_index    (in_list_index),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_merged_value (out_merged_value),
    .out_source_list  (out_source_list),
    .out_status       (out_status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void clear_shadow();
    for (int i = 0; i < LIST_COUNT; i++) begin
      rd_pos[i] = 0;
      wr_pos[i] = 0;
      occupancy[i] = 0;
    end
  endfunction

  function automatic merge_res_t predict_merge(cmd_t c, logic [2:0] idx, logic [31:0] v);
    merge_res_t         r;
    bit                 found;
    int                 best;
    logic signed [31:0] hv;
    logic signed [31:0] bv;
    r = RES_DONE;
    found = 1'b0;
    best = 0;
    bv = 32'sd0;
    case (c)
      CMD_APPEND: begin
        if (occupancy[idx] >= LIST_DEPTH) begin
          r.status = STAT_DROP;
        end else begin
          list_mem[idx][wr_pos[idx]] = v;
          wr_pos[idx] = (wr_pos[idx] + 1) % LIST_DEPTH;
          occupancy[idx]++;
        end
      end
      CMD_POP: begin
        // <= lets a later list take ties
        for (int i = 0; i < LIST_COUNT; i++) begin
          if (occupancy[i] != 0) begin
            hv = list_mem[i][rd_pos[i]];
            if (!found || hv <= bv) begin
              found = 1'b1;
              best = i;
              bv = hv;
            end
          end
        end
        if (found) begin
          rd_pos[best] = (rd_pos[best] + 1) % LIST_DEPTH;
          occupancy[best]--;
          r.value = bv;
          r.src = best[2:0];
        end else begin
          r.status = STAT_EMPTY;
        end
      end
      CMD_CLEAR: clear_shadow();
      default: ;
    endcase
    return r;
  endfunction

  function automatic void add_row(cmd_t c, logic [2:0] idx, logic [31:0] v, bit typed,
                                  merge_res_t want);
    dir_rows.push_back({c, idx, v, typed, want});
  endfunction

  task automatic flag_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    err_count++;
  endtask

  // Present one request, hold it until taken, then record what should come back.
  task automatic issue_request(cmd_t c, logic [2:0] idx, logic [31:0] v, bit typed,
                               merge_res_t want);
    merge_res_t pred;
    start <= 1'b1;
    in_cmd <= c;
    in_list_index <= idx;
    in_value <= v;
    do @(posedge clk); while (busy);
    pred = predict_merge(c, idx, v);
    pending_results.push_back(typed ? want : pred);
    sent_count++;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin : result_check
    merge_res_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result strobe with no request pending");
      end else begin
        want = pending_results.pop_front();
        if (out_merged_value !== want.value)
          flag_mismatch($sformatf("merged_value got %0d want %0d", out_merged_value,
                                  want.value));
        if (out_source_list !== want.src)
          flag_mismatch($sformatf("source_list got %0d want %0d", out_source_list, want.src));
        if (out_status !== want.status)
          flag_mismatch($sformatf("status got %0d want %0d", out_status, want.status));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int                 mode;
    int                 n_app;
    int                 n_pop;
    int                 lst;
    int                 total;
    logic [7:0]         mask;
    logic [31:0]        xv;
    logic signed [31:0] run_val [LIST_COUNT];
    dir_row_t           row;

    clear_shadow();
    for (int i = 0; i < LIST_COUNT; i++) run_val[i] = $urandom;

    // Directed: empty pop, extremes, tie on equal heads, unused command, clear.
    add_row(CMD_POP,    3'd0, 32'h0000_0000, 1'b1, RES_EMPTY);
    add_row(CMD_APPEND, 3'd0, 32'h7fff_ffff, 1'b1, RES_DONE);
    add_row(CMD_APPEND, 3'd7, 32'h8000_0000, 1'b1, RES_DONE);
    add_row(CMD_APPEND, 3'd3, 32'h0000_0000, 1'b0, RES_DONE);
    add_row(CMD_APPEND, 3'd3, 32'hffff_ffff, 1'b0, RES_DONE);
    add_row(CMD_APPEND, 3'd2, 32'h0000_0005, 1'b0, RES_DONE);
    add_row(CMD_APPEND, 3'd5, 32'h0000_0005, 1'b0, RES_DONE);
    add_row(CMD_APPEND, 3'd1, 32'h0000_0005, 1'b0, RES_DONE);
    add_row(CMD_UNUSED, 3'd6, 32'hdead_beef, 1'b1, RES_DONE);
    for (int i = 0; i < 8; i++) add_row(CMD_POP, 3'd0, 32'h0, 1'b0, RES_DONE);
    add_row(CMD_POP,    3'd0, 32'h0000_0000, 1'b1, RES_EMPTY);
    add_row(CMD_APPEND, 3'd6, 32'h0000_007b, 1'b0, RES_DONE);
    add_row(CMD_APPEND, 3'd4, 32'h8000_0000, 1'b0, RES_DONE);
    add_row(CMD_CLEAR,  3'd5, 32'hffff_ffff, 1'b1, RES_DONE);
    add_row(CMD_POP,    3'd7, 32'hffff_ffff, 1'b1, RES_EMPTY);
    add_row(CMD_UNUSED, 3'd7, 32'hffff_ffff, 1'b1, RES_DONE);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      issue_request(row.cmd, row.idx, row.value, row.typed, row.want);
    end

    total = sent_count + RAND_ITEMS;
    while (sent_count < total) begin
      quiet = (sent_count >= total - QUIET_TAIL);
      mode = $urandom_range(0, 9);
      if (mode <= 5) begin
        // non-decreasing runs on a random set of lists, then pops; single-list runs can overflow
        mask = 8'($urandom_range(1, 255));
        if ($urandom_range(0, 2) == 0) mask = 8'd1 << $urandom_range(0, 7);
        n_app = $urandom_range(1, 80);
        n_pop = $urandom_range(n_app / 2, n_app + 3);
        for (int k = 0; k < n_app; k++) begin
          do lst = $urandom_range(0, LIST_COUNT - 1); while (!mask[lst]);
          run_val[lst] = run_val[lst] + $signed($urandom_range(0, 3));
          if ($urandom_range(0, 15) == 0) run_val[lst] = $urandom;
          issue_request(CMD_APPEND, lst[2:0], run_val[lst], 1'b0, RES_DONE);
        end
        for (int k = 0; k < n_pop; k++)
          issue_request(CMD_POP, 3'($urandom), $urandom, 1'b0, RES_DONE);
      end else if (mode <= 7) begin
        repeat ($urandom_range(1, 10))
          issue_request(cmd_t'($urandom_range(0, 3)), 3'($urandom), $urandom, 1'b0, RES_DONE);
      end else if (mode == 8) begin
        issue_request(CMD_CLEAR, 3'($urandom), $urandom, 1'b0, RES_DONE);
      end else begin
        repeat (4) begin
          case ($urandom_range(0, 4))
            0: xv = 32'h8000_0000;
            1: xv = 32'h7fff_ffff;
            2: xv = 32'h0000_0000;
            3: xv = 32'hffff_ffff;
            default: xv = 32'h0000_0001;
          endcase
          issue_request(CMD_APPEND, 3'($urandom), xv, 1'b0, RES_DONE);
        end
        repeat (4) issue_request(CMD_POP, 3'($urandom), $urandom, 1'b0, RES_DONE);
      end
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/kms_pkg.sv
hw/rtl/kms_store.sv
hw/rtl/kms_ptrs.sv
hw/rtl/k_way_sorted_merge.sv
test/tb_k_way_sorted_merge.sv
